// ----- hw/rtl/md5_pkg.sv -----
// Shared types, constants and round functions of the MD5 digest engine.
`timescale 1ns / 1ps

package md5_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 2;
    localparam int COUNT_W = 64;
    localparam int POS_W   = 6;
    localparam int ROUND_W = 6;

    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h80;
    localparam logic [POS_W-1:0]  LEN_POS    = 6'd56;
    localparam logic [POS_W-1:0]  BLOCK_LAST = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [IDX_W-1:0]  WORD_LAST  = 2'd3;

    localparam logic [WORD_W-1:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic                load_init;
        logic                push;
        t_byte_sel           bsel;
        logic [2:0]          len_idx;
        logic                latch_len;
        logic                init_work;
        logic [ROUND_W-1:0]  rd_idx;
        logic                pre_en;
        logic                pre_from_d;
        logic [ROUND_W-1:0]  k_idx;
        logic                round_en;
        logic [ROUND_W-1:0]  round;
        logic                fold;
        logic [IDX_W-1:0]    emit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
    } t_dp_sts;

    // Message word index used by a given round.
    function automatic logic [3:0] md5_g(input logic [ROUND_W-1:0] i);
        logic [3:0] j;
        logic [3:0] g;
        j = i[3:0];
        case (i[5:4])
            2'd0:    g = j;
            2'd1:    g = 4'((j << 2) + j + 4'd1);
            2'd2:    g = 4'((j << 1) + j + 4'd5);
            default: g = 4'((j << 3) - j);
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [ROUND_W-1:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/md5_stream_if.sv -----
// Request and result channel interfaces of the MD5 digest engine.
`timescale 1ns / 1ps

interface md5_in_if import md5_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;

    modport source(output valid, output cmd, output data_byte, input ready);
    modport sink(input valid, input cmd, input data_byte, output ready);
endinterface

interface md5_out_if import md5_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;

    modport source(output valid, output digest_word, output word_index, output last_word,
                   input ready);
    modport sink(input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

// ----- hw/rtl/md5_ctrl.sv -----
// Controller state machine that sequences loading, padding, compression and output.
`timescale 1ns / 1ps

module md5_ctrl import md5_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_word_index,
    output logic             o_last_word,
    output t_dp_cmd          o_dp_cmd,
    input  t_dp_sts          i_dp_sts
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PRE0  = 8'b0000_0010,
        S_PRE1  = 8'b0000_0100,
        S_ROUND = 8'b0000_1000,
        S_FOLD  = 8'b0001_0000,
        S_PAD   = 8'b0010_0000,
        S_LEN   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [ROUND_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_cnt        = r_cnt;
        o_dp_cmd     = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_word_index = r_cnt[IDX_W-1:0];
        o_last_word  = (r_cnt[IDX_W-1:0] == WORD_LAST);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_START: begin
                            o_dp_cmd.load_init = 1'b1;
                        end
                        CMD_DATA: begin
                            o_dp_cmd.push = 1'b1;
                            o_dp_cmd.bsel = BSEL_DATA;
                            if (i_dp_sts.pos == BLOCK_LAST) begin
                                n_state = S_PRE0;
                                n_ret   = S_IDLE;
                            end
                        end
                        CMD_FINISH: begin
                            o_dp_cmd.latch_len = 1'b1;
                            o_dp_cmd.push      = 1'b1;
                            o_dp_cmd.bsel      = BSEL_PAD;
                            n_ret              = S_PAD;
                            n_state            = (i_dp_sts.pos == BLOCK_LAST) ? S_PRE0 : S_PAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PRE0: begin
                o_dp_cmd.init_work = 1'b1;
                o_dp_cmd.rd_idx    = '0;
                n_state            = S_PRE1;
            end
            S_PRE1: begin
                o_dp_cmd.pre_en = 1'b1;
                o_dp_cmd.k_idx  = '0;
                o_dp_cmd.rd_idx = ROUND_W'(1);
                n_cnt           = '0;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_dp_cmd.round_en   = 1'b1;
                o_dp_cmd.round      = r_cnt;
                o_dp_cmd.pre_en     = 1'b1;
                o_dp_cmd.pre_from_d = 1'b1;
                o_dp_cmd.k_idx      = ROUND_W'(r_cnt + ROUND_W'(1));
                o_dp_cmd.rd_idx     = ROUND_W'(r_cnt + ROUND_W'(2));
                n_cnt               = ROUND_W'(r_cnt + ROUND_W'(1));
                if (r_cnt == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_dp_cmd.fold = 1'b1;
                n_cnt         = '0;
                n_state       = r_ret;
            end
            S_PAD: begin
                if (i_dp_sts.pos == LEN_POS) begin
                    n_cnt   = '0;
                    n_state = S_LEN;
                end else begin
                    o_dp_cmd.push = 1'b1;
                    o_dp_cmd.bsel = BSEL_ZERO;
                    if (i_dp_sts.pos == BLOCK_LAST) begin
                        n_ret   = S_PAD;
                        n_state = S_PRE0;
                    end
                end
            end
            S_LEN: begin
                o_dp_cmd.push    = 1'b1;
                o_dp_cmd.bsel    = BSEL_LEN;
                o_dp_cmd.len_idx = r_cnt[2:0];
                n_cnt            = ROUND_W'(r_cnt + ROUND_W'(1));
                if (i_dp_sts.pos == BLOCK_LAST) begin
                    n_ret   = S_EMIT;
                    n_state = S_PRE0;
                end
            end
            S_EMIT: begin
                o_out_valid       = 1'b1;
                o_dp_cmd.emit_idx = r_cnt[IDX_W-1:0];
                if (i_out_ready) begin
                    n_cnt = ROUND_W'(r_cnt + ROUND_W'(1));
                    if (r_cnt[IDX_W-1:0] == WORD_LAST) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/md5_datapath.sv -----
// Datapath with block store, byte counter, chaining words and the round unit.
`timescale 1ns / 1ps

module md5_datapath import md5_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [BYTE_W-1:0] i_data_byte,
    output t_dp_sts           o_sts,
    output logic [WORD_W-1:0] o_digest_word
);

    logic [WORD_W-1:0]  r_ha, r_hb, r_hc, r_hd;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_len;
    logic [WORD_W-1:0]  r_a, r_b, r_c, r_d;
    logic [WORD_W-1:0]  r_pre;
    logic [WORD_W-1:0]  r_mword;
    logic [3:0][BYTE_W-1:0] r_mem [16];

    logic [BYTE_W-1:0]   wr_byte;
    logic [WORD_W-1:0]   f_val;
    logic [WORD_W-1:0]   sum;
    logic [2*WORD_W-1:0] dbl;
    logic [WORD_W-1:0]   n_b;
    logic [WORD_W-1:0]   n_pre;

    assign o_sts.pos = r_count[POS_W-1:0];

    always_comb begin
        case (i_cmd.bsel)
            BSEL_DATA: wr_byte = i_data_byte;
            BSEL_PAD:  wr_byte = PAD_BYTE;
            BSEL_ZERO: wr_byte = '0;
            default:   wr_byte = r_len[{i_cmd.len_idx, 3'b000} +: BYTE_W];
        endcase
    end

    always_comb begin
        case (i_cmd.round[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sum   = f_val + r_pre;
        dbl   = {sum, sum} << md5_rot(i_cmd.round);
        n_b   = r_b + dbl[2*WORD_W-1:WORD_W];
        n_pre = (i_cmd.pre_from_d ? r_d : r_a) + MD5_K[i_cmd.k_idx] + r_mword;
    end

    always_comb begin
        case (i_cmd.emit_idx)
            2'd0:    o_digest_word = r_ha;
            2'd1:    o_digest_word = r_hb;
            2'd2:    o_digest_word = r_hc;
            default: o_digest_word = r_hd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ha    <= IV_A;
            r_hb    <= IV_B;
            r_hc    <= IV_C;
            r_hd    <= IV_D;
            r_count <= '0;
        end else if (i_cmd.load_init) begin
            r_ha    <= IV_A;
            r_hb    <= IV_B;
            r_hc    <= IV_C;
            r_hd    <= IV_D;
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.fold) begin
                r_ha <= r_ha + r_a;
                r_hb <= r_hb + r_b;
                r_hc <= r_hc + r_c;
                r_hd <= r_hd + r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_len) begin
            r_len <= {r_count[COUNT_W-4:0], 3'b000};
        end
        if (i_cmd.init_work) begin
            r_a <= r_ha;
            r_b <= r_hb;
            r_c <= r_hc;
            r_d <= r_hd;
        end else if (i_cmd.round_en) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= n_b;
        end
        if (i_cmd.pre_en) begin
            r_pre <= n_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[POS_W-1:2]][r_count[1:0]] <= wr_byte;
        end
        r_mword <= r_mem[md5_g(i_cmd.rd_idx)];
    end

endmodule

// ----- hw/rtl/md5_digest_engine_top.sv -----
// Top level of the MD5 digest engine: request and result channels, controller and datapath.
// A start or data request is taken while idle; the data byte that fills a 64-byte block starts
// a compression (load in S_PRE0 and S_PRE1, 64 rounds on one shared round unit, one fold).
// No further request is accepted until that compression has finished.
// A finish request writes the padding and the 64-bit bit length, runs one or two compressions,
// then presents the four digest words, one per cycle while the result side is ready.
// Synchronous reset loads the standard chaining words and a zero byte count.
`timescale 1ns / 1ps

module md5_digest_engine_top import md5_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    md5_in_if.sink       i_in,
    md5_out_if.source    o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    md5_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_cmd     (i_in.cmd),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_word_index (o_out.word_index),
        .o_last_word  (o_out.last_word),
        .o_dp_cmd     (dp_cmd),
        .i_dp_sts     (dp_sts)
    );

    md5_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_data_byte   (i_in.data_byte),
        .o_sts         (dp_sts),
        .o_digest_word (o_out.digest_word)
    );

    a_no_request_while_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("Request accepted while digest output is pending.");

    a_block_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == CMD_DATA && dp_sts.pos == BLOCK_LAST)
        |=> !i_in.ready)
        else $error("Block completion did not start compression.");

    a_last_ends_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> !o_out.valid)
        else $error("Output continued after the last digest word.");

    a_rounds_block_requests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.round_en |-> (!i_in.ready && !o_out.valid))
        else $error("Channel active during compression rounds.");

endmodule
